// ----- sv/imap_signature_matcher_assert.svh -----
// Assertion macros used by the matcher RTL.
`ifndef IMAP_SIGNATURE_MATCHER_ASSERT_SVH
`define IMAP_SIGNATURE_MATCHER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IMAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IMAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/imap_sm_pkg.sv -----
package imap_sm_pkg;

    // Window of earlier bytes, and the longest keyword it can complete.
    localparam int WIN_DEPTH = 11;
    localparam int KW_MAX    = WIN_DEPTH + 1;
    localparam int KW_COUNT  = 43;

    // Keyword text, right-aligned: bits [7:0] hold the final character.
    typedef logic [KW_MAX*8-1:0] t_kw_text;
    typedef logic [3:0]          t_kw_len;

    // Byte history, index 0 is the newest byte.
    typedef logic [WIN_DEPTH-1:0][7:0] t_window;

    // Match flags for the current byte.
    typedef struct packed {
        logic kw_hit;
        logic tail_hit;
    } t_match;

    localparam t_kw_text KW_TEXT [KW_COUNT] = '{
        "COMPARATOR", "COMPRESS", "CONVERSIONS", "COPY",
        "CREATE", "DELETE ", "DELETEACL", "EXAMINE",
        "EXPUNGE", "FETCH", "GETACL", "GETQUOTAROOT",
        "GETMETADATA", "GETQUOTA", "IDLE", "LIST",
        "LISTRIGHTS", "LOGIN", "LOGOUT", "LSUB",
        "MYRIGHTS", "NOOP", "NOTIFY", "RENAME",
        "SORT", "SETQUOTA", "SETMETADATA", "SELECT",
        "SETACL", "SEARCH", "STATUS", "STARTTLS",
        "STORE", "SUBSCRIBE", "THREAD", "UID",
        "UNSELECT", "UNSUBSCRIBE", "OK", "BAD",
        "BYE", "NO", "PREAUTH"
    };

    localparam t_kw_len KW_LEN [KW_COUNT] = '{
        4'd10, 4'd8, 4'd11, 4'd4,
        4'd6, 4'd7, 4'd9, 4'd7,
        4'd7, 4'd5, 4'd6, 4'd12,
        4'd11, 4'd8, 4'd4, 4'd4,
        4'd10, 4'd5, 4'd6, 4'd4,
        4'd8, 4'd4, 4'd6, 4'd6,
        4'd4, 4'd8, 4'd11, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd8,
        4'd5, 4'd9, 4'd6, 4'd3,
        4'd8, 4'd11, 4'd2, 4'd3,
        4'd3, 4'd2, 4'd7
    };

    // The signature word that must follow an earlier keyword.
    localparam logic [31:0] TAIL_WORD = "IMAP";

endpackage

// ----- sv/imap_sm_kw_match.sv -----
module imap_sm_kw_match
    import imap_sm_pkg::*;
(
    input  t_window    i_win,
    input  logic [7:0] i_cur,
    output t_match     o_match
);

    // Current byte followed by the history, index 0 is the current byte.
    logic [KW_MAX-1:0][7:0] hay;
    logic [KW_COUNT-1:0]    kw_ends;

    assign hay = {i_win, i_cur};

    // Each keyword is compared on its own; positions past its length are don't-care.
    always_comb begin
        logic ok;
        for (int k = 0; k < KW_COUNT; k++) begin
            ok = 1'b1;
            for (int j = 0; j < KW_MAX; j++) begin
                if ((4'(j) < KW_LEN[k]) && (hay[j] != KW_TEXT[k][8*j +: 8])) begin
                    ok = 1'b0;
                end
            end
            kw_ends[k] = ok;
        end
    end

    assign o_match.kw_hit   = |kw_ends;
    assign o_match.tail_hit = (hay[3:0] == TAIL_WORD);

endmodule

// ----- sv/imap_signature_matcher.sv -----
// Path: the last byte's transaction is captured in the input register, and its result is
// then loaded into the output register that drives o_m_tvalid.
// Throughput: one byte per cycle; the input stalls only while a finished result is
// held in the output register and the next last byte needs that register.
// Reset: i_rst_n is synchronous, active low; it clears the byte window, the keyword,
// signature and end-of-string flags, and both valid bits.
module imap_signature_matcher
    import imap_sm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // is_last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] matched, [7:1] zero
);

    `include "imap_signature_matcher_assert.svh"

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Match state.
    t_window r_win, n_win;
    logic    r_kw, n_kw;
    logic    r_hit, n_hit;
    logic    r_ended, n_ended;

    // Output register.
    logic r_out_valid;
    logic r_out_matched;

    t_match match;
    logic   advance;
    logic   out_free;

    imap_sm_kw_match u_kw_match (
        .i_win   (r_win),
        .i_cur   (r_in_byte),
        .o_match (match)
    );

    // A byte leaves the input register unless it is a last byte facing a full output that is not taken.
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || advance;

    // Capture each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // Next match state for the byte in the input register.
    always_comb begin
        n_win   = r_win;
        n_kw    = r_kw;
        n_hit   = r_hit;
        n_ended = r_ended;
        if (!r_ended) begin
            if (r_in_byte == 8'd0) begin
                n_ended = 1'b1;
            end else begin
                if (r_kw && match.tail_hit) begin
                    n_hit = 1'b1;
                end
                if (match.kw_hit) begin
                    n_kw = 1'b1;
                end
                n_win = {r_win[WIN_DEPTH-2:0], r_in_byte};
            end
        end
    end

    // State update; a last byte clears everything for the next payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_kw    <= 1'b0;
            r_hit   <= 1'b0;
            r_ended <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                r_win   <= '0;
                r_kw    <= 1'b0;
                r_hit   <= 1'b0;
                r_ended <= 1'b0;
            end else begin
                r_win   <= n_win;
                r_kw    <= n_kw;
                r_hit   <= n_hit;
                r_ended <= n_ended;
            end
        end
    end

    // Result register, loaded by a last byte and emptied by the output transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_matched <= n_hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_matched};

    // Checks on the matcher's own state.
    `IMAP_ASSERT_NOW(a_hit_needs_kw, r_hit, r_kw, "signature hit without an earlier keyword")
    `IMAP_ASSERT_NEXT(a_last_gives_result, advance && r_in_last, o_m_tvalid,
        "last byte did not produce a result")
    `IMAP_ASSERT_NEXT(a_last_clears, advance && r_in_last, !r_kw && !r_hit && !r_ended,
        "state not cleared after last byte")
    `IMAP_ASSERT_NEXT(a_ended_freezes, r_ended && !(advance && r_in_last), $stable(r_win),
        "window changed after end of string")

endmodule

// ----- tb/sv/imap_signature_matcher_test.sv -----
module imap_signature_matcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HISTORY_DEPTH = 11;
    localparam int KEYWORD_TOTAL = 43;
    localparam int SESSION_BYTES = 1300;
    localparam int NOISE_BYTES   = 230;
    localparam int MISMATCH_SHOWN = 10;

    // Clock, reset and the driven side of both stream groups, at known values from time zero.
    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;    // is_last
    logic       m_tvalid;
    logic       m_tready = 1'b1;
    logic [7:0] m_tdata;            // [0] matched, [7:1] zero

    // Idle percentages for the sending and the receiving side.
    int src_idle_pct  = 21;
    int sink_idle_pct = 21;

    // Keywords that arm the matcher, and the word that completes the signature.
    string imap_keywords [KEYWORD_TOTAL] = '{
        "COMPARATOR", "COMPRESS", "CONVERSIONS", "COPY",
        "CREATE", "DELETE ", "DELETEACL", "EXAMINE",
        "EXPUNGE", "FETCH", "GETACL", "GETQUOTAROOT",
        "GETMETADATA", "GETQUOTA", "IDLE", "LIST",
        "LISTRIGHTS", "LOGIN", "LOGOUT", "LSUB",
        "MYRIGHTS", "NOOP", "NOTIFY", "RENAME",
        "SORT", "SETQUOTA", "SETMETADATA", "SELECT",
        "SETACL", "SEARCH", "STATUS", "STARTTLS",
        "STORE", "SUBSCRIBE", "THREAD", "UID",
        "UNSELECT", "UNSUBSCRIBE", "OK", "BAD",
        "BYE", "NO", "PREAUTH"
    };
    string signature_word = "IMAP";

    // Predicted matcher state.
    logic [7:0] byte_history [HISTORY_DEPTH];
    logic       keyword_armed;
    logic       signature_seen;
    logic       string_done;

    // Match flags still owed by the block, oldest first.
    logic match_flags_due [$];

    // Payload being assembled by the current test.
    logic [7:0] frame_bytes [$];

    int mismatch_count = 0;
    int bytes_sent     = 0;
    int payloads_sent  = 0;
    int hits_seen      = 0;
    int misses_seen    = 0;

    imap_signature_matcher DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Receiver backpressure.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic void clear_matcher_state();
        foreach (byte_history[i]) byte_history[i] = 8'h00;
        keyword_armed  = 1'b0;
        signature_seen = 1'b0;
        string_done    = 1'b0;
    endfunction

    // True when the word ends with the current byte, preceded by the history.
    function automatic logic word_ends_here(input string word, input logic [7:0] cur);
        int n;
        n = word.len();
        if (n == 0 || n > HISTORY_DEPTH + 1) return 1'b0;
        if (8'(word[n-1]) != cur) return 1'b0;
        for (int i = 0; i + 1 < n; i++) begin
            if (8'(word[n-2-i]) != byte_history[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the predicted matcher by one byte; a last byte yields the match flag.
    function automatic void scan_payload_byte(input logic [7:0] cur, input logic last,
                                              output logic result_due, output logic hit);
        logic armed_before;
        result_due = 1'b0;
        hit        = 1'b0;
        if (!string_done) begin
            if (cur == 8'h00) begin
                string_done = 1'b1;
            end else begin
                armed_before = keyword_armed;
                if (armed_before && word_ends_here(signature_word, cur))
                    signature_seen = 1'b1;
                foreach (imap_keywords[k]) begin
                    if (word_ends_here(imap_keywords[k], cur)) keyword_armed = 1'b1;
                end
                for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                    byte_history[i] = byte_history[i-1];
                byte_history[0] = cur;
            end
        end
        if (last) begin
            result_due = 1'b1;
            hit        = signature_seen;
            clear_matcher_state();
        end
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOWN) $display("MISMATCH: %s", msg);
    endfunction

    // Compare every result transaction with the oldest owed match flag.
    always @(posedge clk) begin
        logic want;
        if (rst_n && m_tvalid && m_tready) begin
            if (match_flags_due.size() == 0) begin
                log_mismatch($sformatf("result 0x%02h with no payload pending", m_tdata));
            end else begin
                want = match_flags_due.pop_front();
                if (m_tdata[0] !== want)
                    log_mismatch($sformatf("matched expected %0b, got %0b", want, m_tdata[0]));
                if (m_tdata[7:1] !== 7'd0)
                    log_mismatch($sformatf("padding expected 0, got 0x%02h", m_tdata[7:1]));
                if (m_tdata[0] === 1'b1) hits_seen++;
                else misses_seen++;
            end
        end
    end

    // Send one byte, waiting for its transaction, and predict its effect.
    task automatic send_byte(input logic [7:0] value, input logic last);
        logic due;
        logic hit;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        scan_payload_byte(value, last, due, hit);
        if (due) match_flags_due.push_back(hit);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        payloads_sent++;
        frame_bytes.delete();
    endtask

    function automatic void add_text(input string text);
        for (int i = 0; i < text.len(); i++) frame_bytes.push_back(8'(text[i]));
    endfunction

    function automatic void add_filler();
        int n;
        n = $urandom_range(4, 1);
        repeat (n) frame_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
    endfunction

    function automatic string pick_keyword();
        return imap_keywords[$urandom_range(KEYWORD_TOTAL - 1)];
    endfunction

    // A keyword followed by the signature word must match.
    task automatic test_keyword_then_signature();
        add_text("NOIMAP");
        send_frame();
    endtask

    // A zero byte ends the string: bytes after it are ignored, and a zero
    // that is also the last byte reports what came before it.
    task automatic test_zero_terminator();
        add_text("OK");
        frame_bytes.push_back(8'h00);
        add_text("IMAP");
        send_frame();
        add_text("BYEIMAP");
        frame_bytes.push_back(8'h00);
        send_frame();
    endtask

    // Single-byte payloads at both ends of the byte range.
    task automatic test_byte_extremes();
        frame_bytes.push_back(8'hff);
        send_frame();
        frame_bytes.push_back(8'h00);
        send_frame();
    endtask

    // Mostly well-formed sessions, with broken and reordered ones mixed in.
    task automatic test_random_sessions(input int budget);
        int start;
        int shape;
        int base;
        string word;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            // A stretch in the middle runs with both sides always ready.
            if (bytes_sent - start >= budget / 3 && bytes_sent - start < budget / 2) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = 21;
                sink_idle_pct = 21;
            end
            shape = $urandom_range(99);
            if ($urandom_range(3) == 0) add_filler();
            if (shape < 55) begin
                add_text(pick_keyword());
                if ($urandom_range(2) == 0) add_filler();
                add_text(signature_word);
            end else if (shape < 65) begin
                // Signature before any keyword.
                add_text(signature_word);
                add_text(pick_keyword());
            end else if (shape < 77) begin
                // Keyword with one letter flipped in case, or cut short.
                word = pick_keyword();
                base = frame_bytes.size();
                add_text(word);
                if ($urandom_range(1) == 0)
                    frame_bytes[base + $urandom_range(word.len() - 1)] ^= 8'h20;
                else
                    void'(frame_bytes.pop_back());
                add_text(signature_word);
            end else if (shape < 87) begin
                // Keyword followed by a near miss of the signature.
                add_text(pick_keyword());
                add_text($urandom_range(1) ? "IMA" : "imap");
            end else begin
                add_text(pick_keyword());
                add_text(pick_keyword());
                add_text(signature_word);
                add_text(signature_word);
            end
            if ($urandom_range(9) == 0)
                frame_bytes.insert($urandom_range(frame_bytes.size()), 8'h00);
            if ($urandom_range(3) == 0) add_filler();
            send_frame();
        end
        src_idle_pct  = 21;
        sink_idle_pct = 21;
    endtask

    // Arbitrary byte payloads, zeros included, of one to twelve bytes.
    task automatic test_random_noise(input int budget);
        int start;
        int n;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            n = $urandom_range(12, 1);
            repeat (n) begin
                if ($urandom_range(9) == 0) frame_bytes.push_back(8'h00);
                else frame_bytes.push_back(8'($urandom_range(255)));
            end
            send_frame();
        end
    endtask

    initial begin
        clear_matcher_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_keyword_then_signature();
        test_zero_terminator();
        test_byte_extremes();
        test_random_sessions(SESSION_BYTES);
        test_random_noise(NOISE_BYTES);
        s_tvalid <= 1'b0;

        // Drain the owed results, then allow for the output latency.
        while (match_flags_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d payloads (%0d bytes): keyword sessions, zero terminators, noise.",
                 payloads_sent, bytes_sent);
        $display("Results seen: %0d matched, %0d not matched, %0d mismatches.",
                 hits_seen, misses_seen, mismatch_count);
        if (mismatch_count == 0 && match_flags_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #1000000;
        $display("Timeout waiting for the matcher.");
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/imap_sm_pkg.sv
sv/imap_sm_kw_match.sv
sv/imap_signature_matcher.sv
tb/sv/imap_signature_matcher_test.sv
